// File: rtl/kssg_pkg.sv
// Package for the knot span search / Greville unit: payload structs, cell-chain
// record, register indexes and operation codes. No dependencies.
`timescale 1ns / 1ps

package kssg_pkg;

	localparam int VALUE_W  = 32;
	localparam int INDEX_W  = 6;
	localparam int OP_W     = 2;
	localparam int DEG_W    = 4;
	// computed knot addresses reach index + degree + 1, so one bit above INDEX_W
	localparam int KADDR_W  = INDEX_W + 1;
	// sum of up to 15 knots of 32 bits
	localparam int SUM_W    = VALUE_W + DEG_W;
	localparam int CNT_W    = DEG_W + 1;
	// one bound-check cell plus enough search cells to halve a 64-wide interval
	localparam int NCELL    = 8;

	localparam int DIV_BITS  = 4;
	localparam int DIV_STEPS = SUM_W / DIV_BITS;
	localparam int DIV_CNT_W = 4;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;

	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_FIND  = 2'd1;
	localparam logic [OP_W-1:0] OP_GREV  = 2'd2;
	// unused code, answered with an all-zero result
	localparam logic [OP_W-1:0] OP_RSVD  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_DEGREE     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_BASIS = 4'd1;

	localparam logic [DEG_W-1:0]   DEGREE_RST     = 4'd2;
	localparam logic [INDEX_W-1:0] LAST_BASIS_RST = 6'd2;

	typedef struct packed {
		logic [OP_W-1:0]           operation;
		logic [INDEX_W-1:0]        index;
		logic signed [VALUE_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic [INDEX_W-1:0]        span;
		logic signed [VALUE_W-1:0] abscissa;
	} result_t;

	typedef struct packed {
		logic [DEG_W-1:0]   degree;
		logic [INDEX_W-1:0] last_basis;
	} cfg_t;

	// record handed from cell to cell
	typedef struct packed {
		logic [OP_W-1:0]           op;
		logic                      init;
		logic                      done;
		logic signed [VALUE_W-1:0] value;
		logic [KADDR_W-1:0]        low;
		logic [KADDR_W-1:0]        high;
		logic [INDEX_W-1:0]        span;
		logic signed [SUM_W-1:0]   sum;
		logic [KADDR_W-1:0]        gaddr;
		logic [CNT_W-1:0]          cnt;
	} chain_t;

endpackage

// File: rtl/kssg_cell.sv
// One cell of the search/accumulate chain: holds one record, does one search
// step or adds one pair of knots, and issues the next knot pair address.
// Depends on kssg_pkg.
`timescale 1ns / 1ps

module kssg_cell import kssg_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  chain_t                    in_data,
	input  cfg_t                      cfg,
	input  logic signed [VALUE_W-1:0] knot_a,
	input  logic signed [VALUE_W-1:0] knot_b,
	output logic                      out_valid,
	output chain_t                    out_data,
	output logic [KADDR_W-1:0]        rd_addr_a,
	output logic [KADDR_W-1:0]        rd_addr_b
);

	logic                    valid_q;
	chain_t                  cur_q;
	chain_t                  nxt;
	logic [KADDR_W-1:0]      lo_n, hi_n;
	logic [KADDR_W:0]        cur_mid_sum, mid_sum_n;
	logic [KADDR_W-1:0]      cur_mid, mid_n;
	logic [KADDR_W-1:0]      p_ext, n_plus1;
	logic [CNT_W-1:0]        take;
	logic signed [SUM_W-1:0] add_a, add_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			cur_q <= in_data;
		end
	end

	assign p_ext       = KADDR_W'(cfg.degree);
	assign n_plus1     = KADDR_W'(cfg.last_basis) + 7'd1;
	assign cur_mid_sum = {1'b0, cur_q.low} + {1'b0, cur_q.high};
	assign cur_mid     = cur_mid_sum[KADDR_W:1];

	assign take  = (cur_q.cnt >= 5'd2) ? 5'd2 : cur_q.cnt;
	assign add_a = (take != 5'd0) ? SUM_W'(knot_a) : '0;
	assign add_b = (take == 5'd2) ? SUM_W'(knot_b) : '0;

	always_comb begin
		nxt  = cur_q;
		lo_n = cur_q.low;
		hi_n = cur_q.high;
		case (cur_q.op)
			OP_FIND: begin
				if (!cur_q.done) begin
					if (cur_q.init) begin
						// bound checks against U[p] and U[n+1]
						nxt.init = 1'b0;
						if (cur_q.value <= knot_a) begin
							nxt.done = 1'b1;
							nxt.span = INDEX_W'(cfg.degree);
						end else if (cur_q.value >= knot_b) begin
							nxt.done = 1'b1;
							nxt.span = cfg.last_basis;
						end else if (p_ext >= n_plus1) begin
							nxt.done = 1'b1;
							nxt.span = cfg.last_basis;
						end else begin
							lo_n = p_ext;
							hi_n = n_plus1;
						end
					end else if ((cur_q.high - cur_q.low) <= 7'd1 ||
							(cur_q.value >= knot_a && cur_q.value < knot_b)) begin
						nxt.done = 1'b1;
						nxt.span = cur_mid[INDEX_W-1:0];
					end else if (cur_q.value < knot_a) begin
						hi_n = cur_mid;
					end else begin
						lo_n = cur_mid;
					end
				end
				nxt.low  = lo_n;
				nxt.high = hi_n;
			end
			OP_GREV: begin
				if (!cur_q.done) begin
					nxt.sum   = cur_q.sum + add_a + add_b;
					nxt.cnt   = cur_q.cnt - take;
					nxt.gaddr = cur_q.gaddr + 7'd2;
					nxt.done  = (cur_q.cnt == take);
				end
			end
			default: ;
		endcase
	end

	assign mid_sum_n = {1'b0, lo_n} + {1'b0, hi_n};
	assign mid_n     = mid_sum_n[KADDR_W:1];

	assign rd_addr_a = (cur_q.op == OP_GREV) ? nxt.gaddr : mid_n;
	assign rd_addr_b = rd_addr_a + 7'd1;

	assign out_valid = valid_q;
	assign out_data  = nxt;

endmodule

// File: rtl/kssg_div.sv
// Sequential signed divider for the Greville mean: 36-bit sum by a 4-bit
// degree, four quotient bits per cycle, truncating toward zero. Depends on kssg_pkg.
`timescale 1ns / 1ps

module kssg_div import kssg_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [SUM_W-1:0]   dividend,
	input  logic [DEG_W-1:0]          divisor,
	output logic                      valid,
	output logic signed [VALUE_W-1:0] quotient
);

	logic                      busy_q;
	logic                      valid_q;
	logic [DIV_CNT_W-1:0]      step_q;
	logic [SUM_W-1:0]          quo_q;
	logic [DEG_W-1:0]          rem_q;
	logic [DEG_W-1:0]          den_q;
	logic                      neg_q;
	logic signed [VALUE_W-1:0] quotient_q;

	logic [SUM_W-1:0] quo_n;
	logic [DEG_W-1:0] rem_n;
	logic [DEG_W:0]   part;
	logic             ge;
	logic [SUM_W-1:0] mag;
	logic [SUM_W-1:0] q_fin;
	logic             last_step;

	assign mag       = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
	assign last_step = (step_q == DIV_CNT_W'(DIV_STEPS - 1));

	// restoring steps on a narrow remainder
	always_comb begin
		quo_n = quo_q;
		rem_n = rem_q;
		part  = '0;
		ge    = 1'b0;
		for (int s = 0; s < DIV_BITS; s++) begin
			part  = {rem_n, quo_n[SUM_W-1]};
			ge    = (part >= {1'b0, den_q});
			quo_n = {quo_n[SUM_W-2:0], ge};
			rem_n = ge ? DEG_W'(part - {1'b0, den_q}) : part[DEG_W-1:0];
		end
	end

	assign q_fin = neg_q ? (~quo_n + 36'd1) : quo_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
			step_q  <= '0;
		end else begin
			valid_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 4'd1;
				if (last_step) begin
					busy_q  <= 1'b0;
					valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			den_q <= divisor;
			neg_q <= dividend[SUM_W-1];
		end else if (busy_q) begin
			quo_q <= quo_n;
			rem_q <= rem_n;
			if (last_step) begin
				quotient_q <= q_fin[VALUE_W-1:0];
			end
		end
	end

	assign valid    = valid_q;
	assign quotient = quotient_q;

endmodule

// File: rtl/knot_span_search_greville_unit.sv
// Top level of the knot span search / Greville unit: knot memory, config
// registers, chain of kssg_cell, kssg_div and the command sequencer. Depends on kssg_pkg.
`timescale 1ns / 1ps
//
//  channel   signals                              transfer when
//  command   start, busy, item                    start && !busy
//  result    done, result                         done (one cycle, no stall)
//  config    cfg_valid, cfg_ready, cfg_index,     cfg_valid && cfg_ready
//            cfg_data
//
// One item at a time. Write and find-span pass once through the 8-cell chain,
// each cell doing one knot-pair read of the two-port knot memory, then raise
// done. Greville makes the chain pass, then 9 divider steps of 4 quotient bits,
// hands the quotient over and raises done. Result is held on result for the
// single cycle done is high. Reset clears control and sets config to its
// reset values; knot memory is not cleared and needs no clearing pass.

module knot_span_search_greville_unit import kssg_pkg::*; #(
	parameter int KNOT_COUNT = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  item_t                 item,
	output logic                  done,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = (KNOT_COUNT > 1) ? $clog2(KNOT_COUNT) : 1;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DIV} state_t;

	state_t  state_q;
	logic    done_q;
	result_t result_q;
	cfg_t    cfg_q;

	logic                      accept;
	logic                      wr_en;
	chain_t                    load;
	logic [KADDR_W-1:0]        g_first;
	logic [KADDR_W-1:0]        init_a, init_b;
	logic [KADDR_W-1:0]        addr_a, addr_b;
	logic signed [VALUE_W-1:0] knots [KNOT_COUNT];
	logic signed [VALUE_W-1:0] rd_a_q, rd_b_q;
	logic                      ok_a_q, ok_b_q;
	logic signed [VALUE_W-1:0] knot_a, knot_b;

	chain_t             cell_in   [NCELL];
	chain_t             cell_out  [NCELL];
	logic [NCELL-1:0]   cell_in_v;
	logic [NCELL-1:0]   cell_valid;
	logic [KADDR_W-1:0] cell_ra   [NCELL];
	logic [KADDR_W-1:0] cell_rb   [NCELL];
	chain_t             last;
	logic               last_valid;

	logic                      div_start;
	logic [DEG_W-1:0]          div_den;
	logic                      div_valid;
	logic signed [VALUE_W-1:0] div_q;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign wr_en     = accept && (item.operation == OP_WRITE) &&
		(32'(item.index) < KNOT_COUNT);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.degree     <= DEGREE_RST;
			cfg_q.last_basis <= LAST_BASIS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEGREE:     cfg_q.degree     <= cfg_data[DEG_W-1:0];
				REG_LAST_BASIS: cfg_q.last_basis <= cfg_data[INDEX_W-1:0];
				default: ;
			endcase
		end
	end

	// record entering the first cell
	assign g_first = (cfg_q.degree == '0) ? '0 : KADDR_W'(item.index) + 7'd1;

	always_comb begin
		load        = '0;
		load.op     = item.operation;
		load.init   = 1'b1;
		load.done   = !(item.operation == OP_FIND || item.operation == OP_GREV);
		load.value  = item.value;
		load.gaddr  = g_first;
		// degree zero averages U[0] and U[1]
		load.cnt    = (cfg_q.degree == '0) ? 5'd2 : CNT_W'(cfg_q.degree);
		if (item.operation == OP_GREV) begin
			init_a = g_first;
			init_b = g_first + 7'd1;
		end else begin
			init_a = KADDR_W'(cfg_q.degree);
			init_b = KADDR_W'(cfg_q.last_basis) + 7'd1;
		end
	end

	// read address comes from whichever cell holds the item
	always_comb begin
		addr_a = init_a;
		addr_b = init_b;
		for (int k = 0; k < NCELL; k++) begin
			if (cell_valid[k]) begin
				addr_a = cell_ra[k];
				addr_b = cell_rb[k];
			end
		end
	end

	// knot memory: one write, two registered reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			knots[AW'(item.index)] <= item.value;
		end
		rd_a_q <= knots[AW'(addr_a)];
		rd_b_q <= knots[AW'(addr_b)];
		ok_a_q <= (32'(addr_a) < KNOT_COUNT);
		ok_b_q <= (32'(addr_b) < KNOT_COUNT);
	end

	// knots past the end of the store read as zero
	assign knot_a = ok_a_q ? rd_a_q : '0;
	assign knot_b = ok_b_q ? rd_b_q : '0;

	assign cell_in[0]   = load;
	assign cell_in_v[0] = accept;

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		if (k > 0) begin : g_link
			assign cell_in[k]   = cell_out[k-1];
			assign cell_in_v[k] = cell_valid[k-1];
		end
		kssg_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cell_in_v[k]),
			.in_data   (cell_in[k]),
			.cfg       (cfg_q),
			.knot_a    (knot_a),
			.knot_b    (knot_b),
			.out_valid (cell_valid[k]),
			.out_data  (cell_out[k]),
			.rd_addr_a (cell_ra[k]),
			.rd_addr_b (cell_rb[k])
		);
	end

	assign last       = cell_out[NCELL-1];
	assign last_valid = cell_valid[NCELL-1];

	assign div_start = (state_q == ST_RUN) && last_valid && (last.op == OP_GREV);
	assign div_den   = (cfg_q.degree == '0) ? 4'd2 : cfg_q.degree;

	kssg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (last.sum),
		.divisor  (div_den),
		.valid    (div_valid),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (last_valid) begin
						if (last.op == OP_GREV) begin
							state_q <= ST_DIV;
						end else begin
							result_q.span     <= (last.op == OP_FIND) ? last.span : '0;
							result_q.abscissa <= '0;
							done_q            <= 1'b1;
							state_q           <= ST_IDLE;
						end
					end
				end
				ST_DIV: begin
					if (div_valid) begin
						result_q.span     <= '0;
						result_q.abscissa <= div_q;
						done_q            <= 1'b1;
						state_q           <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_one_cell: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_valid))
		else $error("more than one chain cell holds an item");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> cell_valid[0])
		else $error("accepted item did not enter the chain");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> (cell_valid == '0))
		else $error("chain holds an item while idle");

	a_search_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(last_valid && last.op == OP_FIND) |-> last.done)
		else $error("span search not finished at end of chain");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_valid |-> (state_q == ST_DIV))
		else $error("divider result outside divide phase");

endmodule

// File: dv/tb.sv
// Self-checking testbench for knot_span_search_greville_unit: directed and random
// knot loads, span searches and Greville queries checked against an in-bench predictor.
// Depends on kssg_pkg and the unit RTL.
`timescale 1ns / 1ps

module tb;
	import kssg_pkg::*;

	localparam int KNOTS       = 64;
	localparam int SETTLE      = 24;     // longest item is a Greville query
	localparam int CYCLE_LIMIT = 400000;
	localparam int MIX_ITEMS   = 1000;
	localparam int FRACTION_BITS_TB = 16;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	item_t                 item;
	logic                  done;
	result_t               result;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	knot_span_search_greville_unit #(.KNOT_COUNT(KNOTS)) dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .item(item),
		.done(done), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic signed [VALUE_W-1:0] knot_image [KNOTS];
	logic [DEG_W-1:0]          deg_cfg  = DEGREE_RST;
	logic [INDEX_W-1:0]        last_cfg = LAST_BASIS_RST;
	result_t                   span_abscissa_q [$];

	int  fails;
	int  accepted_items;
	int  find_items;
	int  grev_items;
	int  settings_used;
	bit  gaps_on;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles", CYCLE_LIMIT);
		$display("status: fail");
		$finish;
	end

	function automatic logic signed [VALUE_W-1:0] knot_at(input int unsigned k);
		if (k >= KNOTS)
			return '0;
		return knot_image[k];
	endfunction

	function automatic logic [INDEX_W-1:0] span_of(input logic signed [VALUE_W-1:0] u);
		int unsigned p, n, lo, hi, mid;
		p = 32'(deg_cfg);
		n = 32'(last_cfg);
		if (u <= knot_at(p))
			return p[INDEX_W-1:0];
		if (u >= knot_at(n + 1))
			return n[INDEX_W-1:0];
		if (p >= n + 1)
			return n[INDEX_W-1:0];
		lo = p;
		hi = n + 1;
		mid = (lo + hi) / 2;
		// halves until the span brackets u, or the interval is one wide
		while (hi - lo > 1 && (u < knot_at(mid) || u >= knot_at(mid + 1))) begin
			if (u < knot_at(mid))
				hi = mid;
			else
				lo = mid;
			mid = (lo + hi) / 2;
		end
		return mid[INDEX_W-1:0];
	endfunction

	function automatic logic signed [VALUE_W-1:0] greville_at(input int unsigned i);
		int unsigned p, j;
		longint      total;
		p = 32'(deg_cfg);
		if (p == 0) begin
			total = (longint'(knot_at(0)) + longint'(knot_at(1))) / 2;
			return total[VALUE_W-1:0];
		end
		total = 0;
		for (j = 0; j < p; j++)
			total += longint'(knot_at(i + j + 1));
		total = total / longint'(p);    // truncates toward zero
		return total[VALUE_W-1:0];
	endfunction

	function automatic result_t span_or_abscissa(input item_t it);
		result_t r;
		r = '0;
		case (it.operation)
			OP_WRITE: knot_image[it.index] = it.value;
			OP_FIND:  r.span = span_of(it.value);
			OP_GREV:  r.abscissa = greville_at(32'(it.index));
			default:  r = '0;
		endcase
		return r;
	endfunction

	always @(posedge clk) begin : check_results
		result_t want;
		if (done) begin
			if (span_abscissa_q.size() == 0) begin
				$error("result with nothing outstanding: span %0d abscissa %0h",
					result.span, result.abscissa);
				fails++;
			end else begin
				want = span_abscissa_q.pop_front();
				if (result.span !== want.span) begin
					$error("span: expected %0d, got %0d", want.span, result.span);
					fails++;
				end
				if (result.abscissa !== want.abscissa) begin
					$error("abscissa: expected %0h, got %0h", want.abscissa,
						result.abscissa);
					fails++;
				end
			end
		end
	end

	// start stays high from one transfer to the next unless a gap is taken
	task automatic send_item(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
			input logic signed [VALUE_W-1:0] val);
		item_t it;
		it.operation = op;
		it.index     = idx;
		it.value     = val;
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			// the gap counts from the first free cycle of the unit
			do @(posedge clk); while (busy);
			repeat ($urandom_range(0, 16)) @(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
		span_abscissa_q.push_back(span_or_abscissa(it));
		accepted_items++;
		if (op == OP_FIND)
			find_items++;
		if (op == OP_GREV)
			grev_items++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (span_abscissa_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_config(input logic [DEG_W-1:0] deg, input logic [INDEX_W-1:0] last);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= REG_DEGREE;
		cfg_data  <= {4'b0, deg};
		do @(posedge clk); while (!cfg_ready);
		deg_cfg = deg;
		cfg_index <= REG_LAST_BASIS;
		cfg_data  <= {2'b0, last};
		do @(posedge clk); while (!cfg_ready);
		last_cfg = last;
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// nondecreasing knots 0..last; optionally clamped (p+1 equal knots at each end)
	task automatic load_knots(input int unsigned last, input int style);
		longint      lo, hi, acc, step_w, r;
		int unsigned p, k;
		bit          clamp;
		p = 32'(deg_cfg);
		clamp = 1'($urandom_range(0, 1));
		case (style)
			0: begin
				lo = longint'(32'sh8000_0000);
				hi = 64'sd2147483647;
			end
			1: begin
				lo = longint'($signed($urandom));
				hi = longint'($signed($urandom));
				if (lo > hi) begin
					r = lo;
					lo = hi;
					hi = r;
				end
			end
			default: begin
				// narrow window: many repeated knots
				lo = longint'($signed($urandom));
				hi = lo + longint'($urandom_range(0, 64));
				if (hi > 64'sd2147483647)
					hi = 64'sd2147483647;
			end
		endcase
		step_w = (hi - lo) * 2 / longint'(last + 1) + 1;
		acc = lo;
		for (k = 0; k <= last; k++) begin
			if (clamp && k + p >= last)
				acc = hi;
			else if (!(clamp && k <= p) && k != 0 && $urandom_range(0, 5) != 0) begin
				r = longint'({$urandom, $urandom} >> 1) % step_w;
				acc += r;
				if (acc > hi)
					acc = hi;
			end
			send_item(OP_WRITE, k[INDEX_W-1:0], acc[VALUE_W-1:0]);
		end
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_param();
		longint lo, hi, r;
		int unsigned k;
		k = $urandom_range(32'(deg_cfg), 63);
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return 32'sh8000_0000;
			2: return 32'sh7fff_ffff;
			3, 4: return knot_at(k);
			5: return knot_at(k) + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
			default: begin
				lo = longint'(knot_at(32'(deg_cfg)));
				hi = longint'(knot_at(32'(last_cfg) + 1));
				if (hi <= lo)
					return $urandom;
				r = lo + longint'({$urandom, $urandom} >> 1) % (hi - lo + 1);
				return r[VALUE_W-1:0];
			end
		endcase
	endfunction

	task automatic test_knot_load();
		int unsigned k;
		logic signed [VALUE_W-1:0] v;
		set_config(4'd2, 6'd5);
		// clamped quadratic vector 0 0 0 1 2 3 4 4 4, then ascending tail
		for (k = 0; k < KNOTS; k++) begin
			if (k < 3)
				v = '0;
			else if (k < 6)
				v = (k - 2) << FRACTION_BITS_TB;
			else if (k < 9)
				v = 32'sh0004_0000;
			else if (k == 63)
				v = 32'sh7fff_ffff;
			else
				v = (k - 4) << FRACTION_BITS_TB;
			send_item(OP_WRITE, k[INDEX_W-1:0], v);
		end
	endtask

	task automatic test_span_bounds();
		send_item(OP_FIND, '0, 32'sh8000_0000);
		send_item(OP_FIND, '0, 32'sh0000_0000);     // equal to U[p]
		send_item(OP_FIND, '1, 32'sh0000_0001);
		send_item(OP_FIND, '0, 32'sh0001_8000);
		send_item(OP_FIND, '0, 32'sh0002_0000);     // exactly on an inner knot
		send_item(OP_FIND, '0, 32'sh0003_ffff);
		send_item(OP_FIND, '0, 32'sh0004_0000);     // equal to U[n+1]
		send_item(OP_FIND, '0, 32'sh7fff_ffff);
	endtask

	task automatic test_greville_cases();
		send_item(OP_GREV, 6'd0, '0);
		send_item(OP_GREV, 6'd3, '1);
		// sum over three knots, two of them negative: quotient truncates toward zero
		set_config(4'd3, 6'd5);
		send_item(OP_WRITE, 6'd1, -32'sd1);
		send_item(OP_WRITE, 6'd2, -32'sd1);
		send_item(OP_GREV, 6'd0, '0);
		// degree zero averages the first two knots whatever the index
		set_config(4'd0, 6'd0);
		send_item(OP_WRITE, 6'd0, -32'sd3);
		send_item(OP_GREV, 6'd17, '0);
		send_item(OP_FIND, '0, 32'sh0000_0000);
		// widest setting: reads run off the end of the store
		set_config(4'd15, 6'd62);
		send_item(OP_GREV, 6'd48, '0);
		send_item(OP_GREV, 6'd63, '0);
		send_item(OP_FIND, '0, 32'sh7fff_ffff);
		send_item(OP_FIND, '0, 32'sh8000_0000);
	endtask

	task automatic test_odd_inputs();
		send_item(OP_RSVD, '1, 32'shffff_ffff);
		// degree above last basis index, bounds undecided by the out-of-order knot
		set_config(4'd7, 6'd3);
		send_item(OP_WRITE, 6'd4, 32'sh7fff_0000);
		send_item(OP_FIND, '0, 32'sh0005_0000);
		// descending stretch: search must still stop
		set_config(4'd1, 6'd9);
		send_item(OP_WRITE, 6'd5, 32'sh0001_0000);
		send_item(OP_FIND, '0, 32'sh0002_8000);
	endtask

	task automatic test_random_mix();
		int base, q, nq, sel;
		int unsigned p, n;
		base = accepted_items;
		while (accepted_items < base + MIX_ITEMS) begin
			if (accepted_items > base + MIX_ITEMS - 150)
				gaps_on = 1'b0;
			if (gaps_on && $urandom_range(0, 9) < 7) begin
				// well-formed: fresh setting, ordered knot vector, then queries
				p = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 15);
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 62)
					: $urandom_range(0, 12);
				set_config(p[DEG_W-1:0], n[INDEX_W-1:0]);
				load_knots((n + p + 1 > 63) ? 63 : n + p + 1, $urandom_range(0, 2));
				nq = $urandom_range(10, 40);
				for (q = 0; q < nq; q++) begin
					sel = $urandom_range(0, 19);
					if (sel == 0)
						send_item(OP_WRITE, 6'($urandom), $urandom);
					else if (sel == 1)
						send_item(OP_RSVD, 6'($urandom), $urandom);
					else if (sel <= 10)
						send_item(OP_FIND, 6'($urandom), pick_param());
					else if ($urandom_range(0, 3) != 0)
						send_item(OP_GREV, 6'($urandom_range(0, n)), $urandom);
					else
						send_item(OP_GREV, 6'($urandom_range(0, 63)), $urandom);
					if (gaps_on && $urandom_range(0, 59) == 0)
						drain();
				end
			end else begin
				if (gaps_on && $urandom_range(0, 1))
					set_config(4'($urandom), 6'($urandom_range(0, 62)));
				for (q = 0; q < 20; q++)
					send_item(2'($urandom), 6'($urandom),
						$urandom_range(0, 1) ? pick_param() : $urandom);
			end
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		item      <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		fails          = 0;
		accepted_items = 0;
		find_items     = 0;
		grev_items     = 0;
		settings_used  = 0;
		gaps_on        = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_knot_load();
		test_span_bounds();
		test_greville_cases();
		test_odd_inputs();
		test_random_mix();

		drain();
		$display("ran %0d items across %0d register settings", accepted_items,
			settings_used);
		$display("checked %0d span searches and %0d Greville means", find_items,
			grev_items);
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
